// ===== rtl/plq_pkg.sv =====
package plq_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int CALIB_W     = 12;
  localparam int HYST_W      = 8;
  localparam int LEVEL_OUT_W = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  localparam int MAX_LEVEL_DEF = 31;
  localparam int ADC_BITS_DEF  = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST      = 2'd2;

  localparam logic [CALIB_W-1:0] CALIB_MIN_RST = 12'd0;
  localparam logic [CALIB_W-1:0] CALIB_MAX_RST = 12'd4095;
  localparam logic [HYST_W-1:0]  HYST_RST      = 8'd6;

  typedef struct packed {
    logic load;
    logic mult;
    logic div_step;
    logic decide;
  } plq_cmd_t;

  typedef struct packed {
    logic out_busy;
  } plq_status_t;

endpackage

// ===== rtl/plq_ctrl.sv =====
module plq_ctrl #(
  parameter int MAX_LEVEL = plq_pkg::MAX_LEVEL_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  plq_pkg::plq_status_t status,
  output plq_pkg::plq_cmd_t    cmd
);

  localparam int LEVEL_W = $clog2(MAX_LEVEL + 1);
  localparam int CNT_W   = (LEVEL_W > 1) ? $clog2(LEVEL_W) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MULT   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(LEVEL_W - 1)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!status.out_busy) begin
          cmd.decide = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== rtl/plq_dp.sv =====
module plq_dp #(
  parameter int MAX_LEVEL = plq_pkg::MAX_LEVEL_DEF,
  parameter int ADC_BITS  = plq_pkg::ADC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [plq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [plq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [plq_pkg::SAMPLE_W-1:0]       pedal_sample,
  input  plq_pkg::plq_cmd_t                  cmd,
  output plq_pkg::plq_status_t               status,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [plq_pkg::LEVEL_OUT_W-1:0]    level,
  output logic                               level_changed
);

  localparam int SW      = plq_pkg::SAMPLE_W;
  localparam int CW      = plq_pkg::CALIB_W;
  localparam int LEVEL_W = $clog2(MAX_LEVEL + 1);
  localparam int NUM_W   = CW + LEVEL_W;
  localparam int SAMP_W  = (ADC_BITS < SW) ? ADC_BITS : SW;
  localparam logic [SW-1:0] SAMPLE_MASK = SW'((32'd1 << SAMP_W) - 32'd1);

  logic [CW-1:0]                 calib_min;
  logic [CW-1:0]                 calib_max;
  logic [plq_pkg::HYST_W-1:0]    hyst_counts;
  logic [SW-1:0]                 raw;
  logic [SW-1:0]                 anchor_sample;
  logic [LEVEL_W-1:0]            cur_level;
  logic                          degen;
  logic [NUM_W-1:0]              rem;
  logic [NUM_W-1:0]              dsh;
  logic [LEVEL_W-1:0]            quot;

  logic [CW-1:0]                 clamped;
  logic [CW-1:0]                 span;
  logic [CW-1:0]                 offs;
  logic                          is_degen;
  logic                          ge;
  logic [SW-1:0]                 moved;
  logic [LEVEL_W-1:0]            cand;
  logic                          take;
  logic [LEVEL_W-1:0]            level_next;

  always_comb begin
    is_degen = (calib_max <= calib_min);
    if (raw < calib_min) begin
      clamped = calib_min;
    end else if (raw > calib_max) begin
      clamped = calib_max;
    end else begin
      clamped = raw;
    end
    offs = clamped - calib_min;
    span = calib_max - calib_min;
    ge   = (rem >= dsh);
    moved = (raw > anchor_sample) ? (raw - anchor_sample) : (anchor_sample - raw);
    cand  = degen ? '0 : quot;
    take  = (cand != cur_level) && (moved >= SW'(hyst_counts));
    level_next = take ? cand : cur_level;
  end

  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_min   <= plq_pkg::CALIB_MIN_RST;
      calib_max   <= plq_pkg::CALIB_MAX_RST;
      hyst_counts <= plq_pkg::HYST_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        plq_pkg::CFG_CALIB_MIN: calib_min   <= cfg_data;
        plq_pkg::CFG_CALIB_MAX: calib_max   <= cfg_data;
        plq_pkg::CFG_HYST:      hyst_counts <= cfg_data[plq_pkg::HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw <= pedal_sample & SAMPLE_MASK;
    end
    if (cmd.mult) begin
      degen <= is_degen;
      rem   <= is_degen ? '0 : NUM_W'(offs) * NUM_W'(MAX_LEVEL);
      dsh   <= NUM_W'(span) << (LEVEL_W - 1);
      quot  <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quot <= LEVEL_W'({quot, ge});
      dsh  <= dsh >> 1;
    end
    if (cmd.decide) begin
      level         <= plq_pkg::LEVEL_OUT_W'(level_next);
      level_changed <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level     <= '0;
      anchor_sample <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.decide) begin
        out_valid <= 1'b1;
        if (take) begin
          cur_level     <= cand;
          anchor_sample <= raw;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/pedal_level_quantizer_core.sv =====
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall   pedal_sample[11:0]
// out       output     out_valid/out_stall level[4:0], level_changed
// cfg       input      cfg_wr_en           cfg_index[1:0], cfg_data[11:0]
//
// Each item passes through accept, clamp and multiply, one restoring-division step per
// quotient bit, then the level decision. The divider iterates over the quotient bits and
// in_stall stays high until the decision, so a new item is taken only in the idle state.
// rst is synchronous: registers return to calib_min 0, calib_max 4095, hysteresis 6,
// level 0, anchor 0. A stalled result waits in the output register; the next item is
// taken meanwhile and holds in the decision step until the result transfer completes.
module pedal_level_quantizer_core #(
  parameter int MAX_LEVEL = plq_pkg::MAX_LEVEL_DEF,
  parameter int ADC_BITS  = plq_pkg::ADC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [plq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [plq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [plq_pkg::SAMPLE_W-1:0]       pedal_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [plq_pkg::LEVEL_OUT_W-1:0]    level,
  output logic                               level_changed
);

  plq_pkg::plq_cmd_t    cmd;
  plq_pkg::plq_status_t status;

  plq_ctrl #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  plq_dp #(
    .MAX_LEVEL (MAX_LEVEL),
    .ADC_BITS  (ADC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pedal_sample  (pedal_sample),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .level         (level),
    .level_changed (level_changed)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import plq_pkg::*;

  localparam int STALL_PCT = 30;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAXLVL = MAX_LEVEL_DEF;

  typedef struct packed {
    logic [LEVEL_OUT_W-1:0] level;
    logic                   changed;
  } level_result_t;

  // Tracks calibration, accepted level and anchor; queues the expected level per sample.
  class level_tracker;
    logic [CALIB_W-1:0]  cal_min;
    logic [CALIB_W-1:0]  cal_max;
    logic [HYST_W-1:0]   hyst;
    int unsigned         level_now;
    logic [SAMPLE_W-1:0] anchor;
    level_result_t       expected_levels[$];
    int                  errors;

    function new();
      cal_min = CALIB_MIN_RST;
      cal_max = CALIB_MAX_RST;
      hyst = HYST_RST;
      level_now = 0;
      anchor = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CALIB_MIN: cal_min = val[CALIB_W-1:0];
        CFG_CALIB_MAX: cal_max = val[CALIB_W-1:0];
        CFG_HYST: hyst = val[HYST_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] sample);
      int unsigned   raw;
      int unsigned   lo;
      int unsigned   hi;
      int unsigned   clamped;
      int unsigned   cand;
      int unsigned   moved;
      level_result_t res;
      raw = sample & ((1 << ADC_BITS_DEF) - 1);
      lo = cal_min;
      hi = cal_max;
      if (hi <= lo) begin
        cand = 0;
      end else begin
        clamped = raw < lo ? lo : (raw > hi ? hi : raw);
        cand = ((clamped - lo) * MAXLVL) / (hi - lo);
      end
      res.changed = 1'b0;
      if (cand != level_now) begin
        moved = raw > anchor ? raw - anchor : anchor - raw;
        if (moved >= hyst) begin
          anchor = raw[SAMPLE_W-1:0];
          level_now = cand;
          res.changed = 1'b1;
        end
      end
      res.level = level_now[LEVEL_OUT_W-1:0];
      expected_levels.push_back(res);
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_level(input logic [LEVEL_OUT_W-1:0] lvl, input logic chg);
      level_result_t want;
      if (expected_levels.size() == 0) begin
        report($sformatf("unexpected result level=%0d changed=%0b", lvl, chg));
      end else begin
        want = expected_levels.pop_front();
        if (lvl !== want.level)
          report($sformatf("level got %0d want %0d", lvl, want.level));
        if (chg !== want.changed)
          report($sformatf("level_changed got %0b want %0b", chg, want.changed));
      end
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_CALIB_MIN;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [SAMPLE_W-1:0]      pedal_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [LEVEL_OUT_W-1:0]   level;
  logic                     level_changed;

  logic                     calm = 1'b0;
  int                       idle_cycles = 0;
  logic [SAMPLE_W-1:0]      last_sample = '0;
  level_tracker             tracker = new();

  pedal_level_quantizer_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pedal_sample(pedal_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .level(level),
    .level_changed(level_changed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_level(level, level_changed);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task send_sample(input logic [SAMPLE_W-1:0] s);
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(0, 99) < STALL_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    pedal_sample <= s;
    do @(posedge clk); while (in_stall);
    tracker.note_sample(s);
    last_sample = s;
  endtask

  task wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'hFFF;
    return v[SAMPLE_W-1:0];
  endfunction

  // Mostly moves around the last sample, the anchor's hysteresis edge and the window edges; some full-range noise.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int h;
    int pick;
    int w;
    h = tracker.hyst;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w = int'(last_sample) + int'($urandom_range(0, 2 * h + 8)) - (h + 4);
    end else if (pick < 55) begin
      w = int'(tracker.anchor) + ($urandom_range(0, 1) ? 1 : -1) *
          (h + int'($urandom_range(0, 2)) - 1);
    end else if (pick < 75) begin
      w = ($urandom_range(0, 1) ? int'(tracker.cal_min) : int'(tracker.cal_max)) +
          int'($urandom_range(0, 8)) - 4;
    end else begin
      w = $urandom_range(0, 4095);
    end
    return clip(w);
  endfunction

  task run_phase(input int lo, input int hi, input int hy, input int items,
                 input logic quiet);
    write_reg(CFG_CALIB_MIN, lo[CFG_DATA_W-1:0]);
    write_reg(CFG_CALIB_MAX, hi[CFG_DATA_W-1:0]);
    write_reg(CFG_HYST, hy[CFG_DATA_W-1:0]);
    calm = quiet;
    repeat (items) send_sample(pick_sample());
    wait_idle();
    calm = 1'b0;
  endtask

  initial begin
    logic [SAMPLE_W-1:0] directed[$];
    int a, b;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default calibration: bucket edge, hysteresis hold and release, bit patterns
    directed = '{12'd0, 12'd5, 12'd132, 12'd133, 12'd4095, 12'd4090, 12'd4089,
                 12'd2048, 12'd2050, 12'd2053, 12'd2054, 12'hAAA, 12'h555,
                 12'hFFF, 12'h000, 12'd1, 12'h800, 12'h7FF, 12'd3, 12'd6};
    foreach (directed[i]) send_sample(directed[i]);
    wait_idle();

    // zero hysteresis, full window
    run_phase(0, 4095, 0, 200, 1'b0);
    // narrowed window, maximum hysteresis
    run_phase(100, 3000, 255, 200, 1'b0);
    // degenerate windows: max below min, and equal
    run_phase(2000, 1000, 3, 120, 1'b0);
    run_phase(1234, 1234, 0, 80, 1'b0);
    run_phase(4095, 0, 1, 40, 1'b0);
    // one-count window at the top of range
    run_phase(4094, 4095, 1, 120, 1'b0);
    // tiny window, hysteresis write carrying junk above its width
    run_phase(0, 31, 12'hF05, 200, 1'b0);
    run_phase(0, 0, 255, 40, 1'b0);
    run_phase(4095, 4095, 0, 40, 1'b0);
    repeat (4) begin
      a = $urandom_range(0, 4095);
      b = $urandom_range(0, 4095);
      if (a > b && $urandom_range(0, 3) != 0) begin
        int t;
        t = a;
        a = b;
        b = t;
      end
      run_phase(a, b, $urandom_range(0, 4095), 150, 1'b0);
    end
    // back to reset calibration, no idling on either side
    run_phase(0, 4095, 6, 150, 1'b1);

    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d expected results never arrived", tracker.pending()));
    if (tracker.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
